// ----- hw/rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and constants of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // default screen geometry
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int CURSOR_W  = 11;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FG = 2'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  // register reset values
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'h0;
  localparam logic [COLOR_W-1:0] DEF_FG_RESET = 4'h7;

  // input request
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } in_t;

  // result request
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CHAR_W-1:0]   read_char;
    logic [CHAR_W-1:0]   read_attr;
    logic                scrolled;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic set_fg;
    logic restore_fg;
    logic home_cursor;
    logic cnt_clr;
    logic fill_we;
    logic fill_init;
    logic scroll_step;
    logic scroll_done;
    logic print;
    logic read_issue;
    logic emit;
    logic emit_read;
    logic emit_scrolled;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                is_color;
    logic                cursor_full;
    logic                read_ok;
    logic                slot_free;
    logic                fill_last;
    logic                scroll_last;
  } status_t;

endpackage

// ----- hw/rtl/text_console_char_engine_core.sv -----
// ----------------------------------------------------------------------------
// text_console_char_engine_core
// Text-mode console engine: screen memory of character and attribute cells,
// cursor and active foreground color, driven by put, read and clear requests.
// ----------------------------------------------------------------------------
// After reset the block blanks all ROWS*COLS cells of the screen memory
// (2000 by default) one cell per cycle and holds in_stall high meanwhile;
// configuration writes are taken during that pass. A request is accepted in
// the idle state and worked in the execute state, which waits until the
// result register is free; a cell read adds a wait state for the registered
// read of the screen memory. A clear walks the memory one cell a cycle, and
// a print that scrolls first copies the screen up one row through the
// memory's read and write ports, one cell a cycle, and blanks the last row.
// Results sit in an output register, so the next request is accepted while
// a result waits to be taken.
module text_console_char_engine_core #(
  parameter int ROWS = tcce_pkg::ROWS_DEF,
  parameter int COLS = tcce_pkg::COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tcce_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcce_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcce_pkg::COLOR_W-1:0]   cfg_wdata
);
  import tcce_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath with screen memory
  tcce_dpath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ----- hw/rtl/tcce_ram.sv -----
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer of the console: decodes each request and steps the datapath
// through print, read, scroll and screen fill operations.
// ----------------------------------------------------------------------------
module tcce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcce_pkg::status_t status,
  output tcce_pkg::cmd_t    cmd
);
  import tcce_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_PRINT  = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        // power-up blanking of the whole screen
        cmd.fill_we   = 1'b1;
        cmd.fill_init = 1'b1;
        if (status.fill_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait here until the result register can take a result
        if (status.slot_free) begin
          unique case (status.action)
            ACT_PUT: begin
              if (status.is_color) begin
                cmd.set_fg = 1'b1;
                cmd.emit   = 1'b1;
                state_nxt  = S_IDLE;
              end else if (status.cursor_full) begin
                cmd.cnt_clr = 1'b1;
                state_nxt   = S_SCROLL;
              end else begin
                cmd.print = 1'b1;
                cmd.emit  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            ACT_READ: begin
              if (status.read_ok) begin
                cmd.read_issue = 1'b1;
                state_nxt      = S_RDWAIT;
              end else begin
                cmd.emit  = 1'b1;
                state_nxt = S_IDLE;
              end
            end
            ACT_CLEAR: begin
              cmd.restore_fg  = 1'b1;
              cmd.home_cursor = 1'b1;
              cmd.cnt_clr     = 1'b1;
              state_nxt       = S_FILL;
            end
            ACT_NONE: begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_we = 1'b1;
        if (status.fill_last) begin
          cmd.cnt_clr = 1'b1;
          cmd.emit    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.scroll_last) begin
          cmd.scroll_done = 1'b1;
          cmd.cnt_clr     = 1'b1;
          state_nxt       = S_PRINT;
        end
      end
      S_PRINT: begin
        cmd.print         = 1'b1;
        cmd.emit          = 1'b1;
        cmd.emit_scrolled = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_RDWAIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ----- hw/rtl/tcce_dpath.sv -----
// ----------------------------------------------------------------------------
// tcce_dpath
// Datapath of the console: request and color registers, cursor tracking,
// sweep counter, screen memory and result register.
// ----------------------------------------------------------------------------
module tcce_dpath #(
  parameter int ROWS = tcce_pkg::ROWS_DEF,
  parameter int COLS = tcce_pkg::COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcce_pkg::cmd_t                      cmd,
  output tcce_pkg::status_t                   status,
  input  tcce_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tcce_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcce_pkg::COLOR_W-1:0]        cfg_wdata
);
  import tcce_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int MOVED  = (ROWS - 1) * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLS);

  localparam logic [CNT_W-1:0] CELLS_C    = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] CELLS_M1_C = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0] MOVED_C    = CNT_W'(MOVED);
  localparam logic [CNT_W-1:0] COLS_C     = CNT_W'(COLS);
  localparam logic [COL_W-1:0] LAST_COL_C = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW_C = ROW_W'(ROWS - 1);

  // registers
  in_t                item_r;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic [COLOR_W-1:0] dflt_r, dflt_nxt;
  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [CNT_W-1:0]   cursor_r, cursor_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r;

  // memory port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              newline;
  logic              scroll_rd;
  logic              scroll_wr;
  logic              slot_free;
  logic [CELL_W-1:0] blank_cell;

  assign newline   = (item_r.char_code == CHAR_NEWLINE);
  assign slot_free = !out_valid_r || !out_stall;
  assign scroll_rd = cmd.scroll_step && (cnt_r < MOVED_C);
  assign scroll_wr = cmd.scroll_step && (cnt_r != '0);

  // blank cell, fixed attribute during power-up blanking
  assign blank_cell = cmd.fill_init ? {BG_RESET, DEF_FG_RESET, CHAR_SPACE}
                                    : {bg_r, fg_r, CHAR_SPACE};

  // status to the controller
  always_comb begin
    status.action      = item_r.action;
    status.is_color    = (item_r.char_code[7:4] == 4'h0) &&
                         (item_r.char_code != '0) && !newline;
    status.cursor_full = (cursor_r >= CELLS_C);
    status.read_ok     = (int'(item_r.cell_index) < CELLS);
    status.slot_free   = slot_free;
    status.fill_last   = (cnt_r == CELLS_M1_C);
    status.scroll_last = (cnt_r == CELLS_C);
  end

  // configuration registers
  always_comb begin
    bg_nxt   = bg_r;
    dflt_nxt = dflt_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BACKGROUND: bg_nxt   = cfg_wdata;
        REG_DEFAULT_FG: dflt_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // active foreground
  always_comb begin
    fg_nxt = fg_r;
    priority if (cmd.set_fg) begin
      fg_nxt = item_r.char_code[COLOR_W-1:0];
    end else if (cmd.restore_fg) begin
      fg_nxt = dflt_r;
    end
  end

  // cursor as linear cell plus row and column
  always_comb begin
    cursor_nxt = cursor_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    priority if (cmd.home_cursor) begin
      cursor_nxt = '0;
      row_nxt    = '0;
      col_nxt    = '0;
    end else if (cmd.scroll_done) begin
      cursor_nxt = MOVED_C;
      row_nxt    = LAST_ROW_C;
      col_nxt    = '0;
    end else if (cmd.print) begin
      if (newline) begin
        cursor_nxt = cursor_r + COLS_C - CNT_W'(col_r);
        row_nxt    = row_r + 1'b1;
        col_nxt    = '0;
      end else if (col_r == LAST_COL_C) begin
        cursor_nxt = cursor_r + 1'b1;
        row_nxt    = row_r + 1'b1;
        col_nxt    = '0;
      end else begin
        cursor_nxt = cursor_r + 1'b1;
        col_nxt    = col_r + 1'b1;
      end
    end
  end

  // sweep counter for fill and scroll
  always_comb begin
    cnt_nxt = cnt_r;
    priority if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.fill_we || cmd.scroll_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // memory write port: fill, scroll copy, print
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(cursor_r);
    ram_wdata = {bg_r, fg_r, item_r.char_code};
    priority if (cmd.fill_we) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(cnt_r);
      ram_wdata = blank_cell;
    end else if (scroll_wr) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(cnt_r - 1'b1);
      ram_wdata = (cnt_r <= MOVED_C) ? ram_rdata : blank_cell;
    end else if (cmd.print && !newline) begin
      ram_we = 1'b1;
    end
  end

  // memory read port: cell read or next row source during scroll
  assign ram_re    = cmd.read_issue || scroll_rd;
  assign ram_raddr = cmd.read_issue ? ADDR_W'(item_r.cell_index)
                                    : ADDR_W'(cnt_r + COLS_C);

  // result register
  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r        <= BG_RESET;
      dflt_r      <= DEF_FG_RESET;
      fg_r        <= DEF_FG_RESET;
      cursor_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bg_r        <= bg_nxt;
      dflt_r      <= dflt_nxt;
      fg_r        <= fg_nxt;
      cursor_r    <= cursor_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.emit) begin
      out_data_r.cursor_position <= CURSOR_W'(cursor_nxt);
      out_data_r.read_char       <= cmd.emit_read ? ram_rdata[7:0] : '0;
      out_data_r.read_attr       <= cmd.emit_read ? ram_rdata[15:8] : '0;
      out_data_r.scrolled        <= cmd.emit_scrolled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result is only produced into a free result register
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("result produced while result register is occupied");

  // row and column always match the linear cursor
  a_cursor_rc: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cursor_r) == int'(row_r) * COLS + int'(col_r))
    else $error("cursor row and column out of step");

  // a print always lands on the screen, scroll having run first
  a_print_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.print |-> (cursor_r < CELLS_C))
    else $error("print with cursor past the end of the screen");

endmodule

// ----- bench/text_console_char_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_char_engine_core testbench
// Self-checking bench for the text console engine. A table of directed
// requests covers reset contents, field extremes, color codes, newline,
// clear, out-of-screen reads and the unused action. Random line-shaped
// traffic then fills the screen and forces scrolls. Every result is compared
// field by field with the table's typed result or an in-bench model of the
// screen, cursor and colors. Three phases vary sender and receiver idling
// and the color registers, and one receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import tcce_pkg::*;

  localparam int CELLS = ROWS_DEF * COLS_DEF;
  localparam int LAST_ROW = (ROWS_DEF - 1) * COLS_DEF;
  localparam int MAX_INDEX = (1 << INDEX_W) - 1;
  localparam int HOLD_CYC = 400;
  localparam int DRAIN_CYC = 64;
  localparam longint LIMIT_TU = 64'd60_000_000;
  // register index past the two real registers, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0] cfg_wdata = '0;

  text_console_char_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #(LIMIT_TU);
    $display("text_console_char_engine_core verification failed");
    $finish;
  end

  // screen model: attribute in the high byte, character in the low byte
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned cursor_model;
  logic [COLOR_W-1:0] fg_now;
  logic [COLOR_W-1:0] bg_reg;
  logic [COLOR_W-1:0] deffg_reg;

  out_t result_q [$];
  out_t want_res;
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int n_req = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_scrolls = 0;
  int n_results = 0;
  logic rx_hold_req = 1'b0;
  logic rx_hold_started = 1'b0;
  int rx_hold_left = 0;

  // directed table: request, whether the result is typed in, typed result
  typedef struct packed {
    in_t  req;
    logic typed;
    out_t res;
  } dir_row_t;

  dir_row_t dir_rows [0:23] = '{
    // blank screen after reset
    '{'{ACT_READ,  8'hFF,        11'd0},    1'b1, '{11'd0,  CHAR_SPACE, 8'h07, 1'b0}},
    '{'{ACT_READ,  8'h00,        11'd1999}, 1'b1, '{11'd0,  CHAR_SPACE, 8'h07, 1'b0}},
    // reads off the screen and the unused action
    '{'{ACT_READ,  8'h55,        11'd2000}, 1'b1, '{11'd0,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_READ,  8'hAA,        11'd2047}, 1'b1, '{11'd0,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_NONE,  8'hFF,        11'd2047}, 1'b1, '{11'd0,  8'h00, 8'h00, 1'b0}},
    // prints and color codes at both ends of their ranges
    '{'{ACT_PUT,   8'h41,        11'd2047}, 1'b1, '{11'd1,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_PUT,   8'h01,        11'd0},    1'b1, '{11'd1,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_PUT,   8'h00,        11'd1365}, 1'b1, '{11'd2,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_PUT,   8'h0F,        11'd682},  1'b1, '{11'd2,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_PUT,   8'hFF,        11'd0},    1'b1, '{11'd3,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_PUT,   8'h10,        11'd0},    1'b1, '{11'd4,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_PUT,   CHAR_NEWLINE, 11'd0},    1'b1, '{11'd80, 8'h00, 8'h00, 1'b0}},
    // read back what was printed
    '{'{ACT_READ,  8'h00,        11'd0},    1'b1, '{11'd80, 8'h41, 8'h07, 1'b0}},
    '{'{ACT_READ,  8'h00,        11'd1},    1'b1, '{11'd80, 8'h00, 8'h01, 1'b0}},
    '{'{ACT_READ,  8'h00,        11'd2},    1'b1, '{11'd80, 8'hFF, 8'h0F, 1'b0}},
    '{'{ACT_READ,  8'h00,        11'd3},    1'b1, '{11'd80, 8'h10, 8'h0F, 1'b0}},
    '{'{ACT_READ,  8'h00,        11'd4},    1'b1, '{11'd80, CHAR_SPACE, 8'h07, 1'b0}},
    '{'{ACT_PUT,   8'h09,        11'd0},    1'b0, '0},
    '{'{ACT_PUT,   CHAR_NEWLINE, 11'd0},    1'b0, '0},
    '{'{ACT_PUT,   8'h80,        11'd0},    1'b0, '0},
    // clear restores the default color and homes the cursor
    '{'{ACT_CLEAR, 8'hFF,        11'd2047}, 1'b1, '{11'd0,  8'h00, 8'h00, 1'b0}},
    '{'{ACT_READ,  8'h00,        11'd160},  1'b1, '{11'd0,  CHAR_SPACE, 8'h07, 1'b0}},
    '{'{ACT_PUT,   8'h7E,        11'd0},    1'b0, '0},
    '{'{ACT_READ,  8'h00,        11'd0},    1'b0, '0}
  };

  // next result of the console for one request, updates the model
  function automatic out_t console_step(input in_t r);
    out_t res;
    res = '0;
    case (r.action)
      ACT_PUT: begin
        if (r.char_code >= 8'd1 && r.char_code <= 8'd15 && r.char_code != CHAR_NEWLINE) begin
          fg_now = r.char_code[COLOR_W-1:0];
        end else begin
          // cursor ran off the bottom: scroll up one row first
          if (cursor_model >= CELLS) begin
            for (int i = 0; i < LAST_ROW; i++) screen_model[i] = screen_model[i + COLS_DEF];
            for (int i = LAST_ROW; i < CELLS; i++) screen_model[i] = {bg_reg, fg_now, CHAR_SPACE};
            cursor_model = LAST_ROW;
            res.scrolled = 1'b1;
          end
          if (r.char_code == CHAR_NEWLINE) begin
            cursor_model = (cursor_model / COLS_DEF + 1) * COLS_DEF;
          end else begin
            screen_model[cursor_model] = {bg_reg, fg_now, r.char_code};
            cursor_model++;
          end
        end
      end
      ACT_READ: begin
        if (r.cell_index < CELLS) {res.read_attr, res.read_char} = screen_model[r.cell_index];
      end
      ACT_CLEAR: begin
        fg_now = deffg_reg;
        for (int i = 0; i < CELLS; i++) screen_model[i] = {bg_reg, fg_now, CHAR_SPACE};
        cursor_model = 0;
      end
      default: ;
    endcase
    res.cursor_position = cursor_model[CURSOR_W-1:0];
    return res;
  endfunction

  // offer one request, wait for it to be taken and queue its result
  task automatic send_req(input in_t r, input logic typed, input out_t typed_res);
    out_t pred;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pred = console_step(r);
    result_q.push_back(typed ? typed_res : pred);
    n_req++;
    if (r.action == ACT_READ) n_reads++;
    if (r.action == ACT_CLEAR) n_clears++;
    if (pred.scrolled) n_scrolls++;
  endtask

  // drop valid and wait for every queued result
  task automatic settle(input int unsigned extra);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // write both color registers and the unused index, block idle
  task automatic write_regs(input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg);
    cfg_we <= 1'b1;
    cfg_index <= REG_BACKGROUND;
    cfg_wdata <= bg;
    bg_reg = bg;
    @(posedge clk);
    cfg_index <= REG_DEFAULT_FG;
    cfg_wdata <= fg;
    deffg_reg = fg;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= COLOR_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // text byte: mostly printable, some color codes and nulls
  function automatic logic [CHAR_W-1:0] text_byte();
    int unsigned p;
    int unsigned c;
    p = $urandom_range(0, 99);
    c = $urandom_range(1, 14);
    if (p < 8) return CHAR_W'(c >= 10 ? c + 1 : c);
    if (p < 10) return 8'h00;
    return CHAR_W'($urandom_range(16, 255));
  endfunction

  // read address: anywhere, just behind the cursor, or off the screen
  function automatic logic [INDEX_W-1:0] read_index();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return INDEX_W'($urandom_range(0, CELLS - 1));
    if (p < 80) return INDEX_W'((cursor_model + CELLS - $urandom_range(1, COLS_DEF)) % CELLS);
    return INDEX_W'($urandom_range(CELLS, MAX_INDEX));
  endfunction

  // random traffic: text lines, read bursts, raw noise and clears
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    in_t r;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 60)) begin
          r.action = ACT_PUT;
          r.char_code = text_byte();
          r.cell_index = INDEX_W'($urandom);
          send_req(r, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 4) != 0) begin
          r.char_code = CHAR_NEWLINE;
          send_req(r, 1'b0, '0);
          sent++;
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 8)) begin
          r.action = ACT_READ;
          r.char_code = CHAR_W'($urandom);
          r.cell_index = read_index();
          send_req(r, 1'b0, '0);
          sent++;
        end
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 4)) begin
          r.action = ACTION_W'($urandom);
          r.char_code = CHAR_W'($urandom);
          r.cell_index = INDEX_W'($urandom);
          send_req(r, 1'b0, '0);
          if (r.action != ACT_NONE) sent++;
        end
      end else begin
        r.action = ACT_CLEAR;
        r.char_code = CHAR_W'($urandom);
        r.cell_index = INDEX_W'($urandom);
        send_req(r, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // flag one field that differs
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: compare taken results, drive stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want_res = result_q.pop_front();
        check_field("cursor_position", 16'(want_res.cursor_position),
                    16'(out_data.cursor_position));
        check_field("read_char", 16'(want_res.read_char), 16'(out_data.read_char));
        check_field("read_attr", 16'(want_res.read_attr), 16'(out_data.read_attr));
        check_field("scrolled", 16'(want_res.scrolled), 16'(out_data.scrolled));
      end
    end
    // long hold-off once asked, otherwise random stalls
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold_req && !rx_hold_started) begin
      rx_hold_started <= 1'b1;
      rx_hold_left <= HOLD_CYC;
      out_stall <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  // main sequence
  initial begin
    bg_reg = BG_RESET;
    deffg_reg = DEF_FG_RESET;
    fg_now = DEF_FG_RESET;
    cursor_model = 0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = {BG_RESET, DEF_FG_RESET, CHAR_SPACE};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    tx_idle = 21;
    rx_idle = 85;
    foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
    settle(4);
    write_regs(4'hF, 4'h0);
    run_random(620);

    // roles swapped
    settle(4);
    tx_idle = 85;
    rx_idle = 21;
    write_regs(4'h0, 4'hF);
    run_random(620);

    // no idling, one long receiver hold-off to back the block up
    settle(4);
    tx_idle = 0;
    rx_idle = 0;
    write_regs(COLOR_W'($urandom), COLOR_W'($urandom));
    rx_hold_req <= 1'b1;
    run_random(610);

    settle(DRAIN_CYC);
    $display("covered %0d requests and %0d results: %0d cell reads, %0d clears, %0d scrolls",
             n_req, n_results, n_reads, n_clears, n_scrolls);
    $display("three stall mixes, four color settings, %0d mismatches", errors);
    if (errors == 0) begin
      $display("text_console_char_engine_core verification clean");
    end else begin
      $display("text_console_char_engine_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ram.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/tcce_dpath.sv
hw/rtl/text_console_char_engine_core.sv
bench/text_console_char_engine_core_tb.sv
